/* hw/rtl/wfs_pkg.sv */
// Shared types, codes and constants of the wall-following junction steering block.
`timescale 1ns / 1ps

package wfs_pkg;

    // Action codes of a result beat.
    localparam logic [2:0] ACT_LEFT   = 3'd0;
    localparam logic [2:0] ACT_FWD    = 3'd1;
    localparam logic [2:0] ACT_RIGHT  = 3'd2;
    localparam logic [2:0] ACT_AROUND = 3'd3;
    localparam logic [2:0] ACT_BRAKE  = 3'd4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_OPEN   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_OPEN  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_DIST  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEIL   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DUTY   = 4'd7;
    localparam int CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [15:0] RST_PROP_GAIN  = 16'd524;
    localparam logic [15:0] RST_DERIV_GAIN = 16'd33;
    localparam logic [11:0] RST_LEFT_OPEN  = 12'd3900;
    localparam logic [11:0] RST_RIGHT_OPEN = 12'd3900;
    localparam logic [15:0] RST_FRONT_DIST = 16'd100;
    localparam logic [14:0] RST_DUTY_CEIL  = 15'd25600;
    localparam logic [14:0] RST_DUTY_FLOOR = 15'd0;
    localparam logic [14:0] RST_BASE_DUTY  = 15'd4608;

    // Default number of consecutive open ticks that confirm a side opening.
    localparam int CONFIRM_TICKS_DEF = 5;

    // Derivative scaling: microseconds per second, and the interval used
    // on the first PD step.
    localparam logic [19:0] DERIV_SCALE = 20'd1000000;
    localparam logic [19:0] FIRST_DT    = 20'd10000;

    // Width of the derivative numerator and quotient; the divider retires
    // one quotient bit per step.
    localparam int QUO_W = 33;

    typedef struct packed {
        logic [11:0] right_side;
        logic [11:0] left_side;
        logic [11:0] left_diag;
        logic [11:0] right_diag;
        logic [15:0] front_distance;
        logic [19:0] interval_us;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  action;
        logic [14:0] left_drive;
        logic [14:0] right_drive;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic prep;
        logic div_step;
        logic mul_lo;
        logic mul_hi;
        logic corr;
        logic drive;
        logic clamp;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic forward;
    } t_dp_stat;

endpackage

/* hw/rtl/wall_follow_pd_junction_steer.sv */
// Top level of the wall-following PD steering block with junction detection.
//
//  Channel | Direction | Handshake               | Beat contents
//  --------+-----------+-------------------------+------------------------------
//  input   | in        | i_in_valid / o_in_ready | t_in_item: IR samples, front,
//          |           |                         | interval
//  output  | out       | o_out_valid/i_out_ready | t_out_item: action, drives
//  config  | in        | i_cfg_valid/o_cfg_ready | register index and data
//
// A forward beat passes from acceptance through the setup step, the one-bit-per-cycle
// divider of the derivative (33 steps), the two multiply steps and the rounding, drive
// and clamp steps to a ready result. Other actions go from setup to the output.
// One item is in work at a time; the next one is taken once the result sits in
// the output register, which holds it through any output stall.
// Reset is synchronous and active low and restores the register defaults.
`timescale 1ns / 1ps

module wall_follow_pd_junction_steer
    import wfs_pkg::*;
#(
    parameter int CONFIRM_TICKS = CONFIRM_TICKS_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    wfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    wfs_datapath #(
        .CONFIRM_TICKS (CONFIRM_TICKS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_data  (o_out_data)
    );

    // One item at a time: an accepted beat closes the input until it is done.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while an item is still in work");

    a_action_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.action <= ACT_BRAKE))
        else $error("result beat carries an undefined action");

    a_idle_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.action != ACT_FWD))
            |-> (o_out_data.left_drive == '0 && o_out_data.right_drive == '0))
        else $error("non-forward result beat drives the motors");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("output register overwritten before its beat was taken");

endmodule

/* hw/rtl/wfs_ctrl.sv */
// Sequencer of the steering block: handshakes, step commands and divider count.
`timescale 1ns / 1ps

module wfs_ctrl
    import wfs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP  = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_MLO   = 4'd3;
    localparam logic [3:0] ST_MHI   = 4'd4;
    localparam logic [3:0] ST_CORR  = 4'd5;
    localparam logic [3:0] ST_DRIVE = 4'd6;
    localparam logic [3:0] ST_CLAMP = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = i_stat.forward ? ST_DIV : ST_EMIT;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_MLO;
                end
            end
            ST_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_MHI;
            end
            ST_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ST_CORR;
            end
            ST_CORR: begin
                o_cmd.corr = 1'b1;
                n_state    = ST_DRIVE;
            end
            ST_DRIVE: begin
                o_cmd.drive = 1'b1;
                n_state     = ST_CLAMP;
            end
            ST_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                // Wait here until the output register can take the beat.
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* hw/rtl/wfs_datapath.sv */
// Datapath of the steering block: registers, run counters, action choice and PD arithmetic.
`timescale 1ns / 1ps

module wfs_datapath
    import wfs_pkg::*;
#(
    parameter int CONFIRM_TICKS = CONFIRM_TICKS_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output t_out_item             o_out_data
);

    localparam int RUN_W = $clog2(CONFIRM_TICKS + 1);
    localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(CONFIRM_TICKS);

    // Configuration registers.
    logic [15:0] r_kp, r_kd;
    logic [11:0] r_left_lvl, r_right_lvl;
    logic [15:0] r_front_lvl;
    logic [14:0] r_ceil, r_floor, r_base;

    // Block state.
    logic signed [12:0] r_prev_error;
    logic [RUN_W-1:0]   r_left_run, r_right_run;
    logic               r_pd_started;

    // Per-item working registers.
    logic [2:0]         r_action;
    logic signed [12:0] r_err;
    logic [12:0]        r_diff_mag;
    logic               r_diff_neg;
    logic [19:0]        r_dt;
    logic signed [29:0] r_pterm;
    logic [QUO_W-1:0]   r_quo;
    logic [19:0]        r_rem;
    logic [32:0]        r_dacc;
    logic [48:0]        r_dterm;
    logic signed [43:0] r_corr;
    logic signed [45:0] r_lsum, r_rsum;
    logic [14:0]        r_ldrive, r_rdrive;
    t_out_item          r_out;

    logic [RUN_W-1:0]   n_left_run, n_right_run;
    logic [2:0]         n_action;
    logic signed [12:0] w_err;
    logic signed [13:0] w_diff, w_diff_abs;
    logic [19:0]        w_dt;
    logic [20:0]        w_shift;
    logic [20:0]        w_trial;
    logic [32:0]        w_lo_prod;
    logic [31:0]        w_hi_prod;
    logic signed [51:0] w_dterm_s, w_sum;
    logic signed [45:0] w_corr_x, w_base_x;

    function automatic logic [14:0] clamp_duty(
        input logic signed [45:0] v,
        input logic [14:0]        hi,
        input logic [14:0]        lo
    );
        logic signed [45:0] t;
        t = v;
        if (t > $signed({31'b0, hi})) begin
            t = $signed({31'b0, hi});
        end
        if (t < $signed({31'b0, lo})) begin
            t = $signed({31'b0, lo});
        end
        return t[14:0];
    endfunction

    assign o_stat.forward = (r_action == ACT_FWD);
    assign o_out_data     = r_out;

    // Run counters and action choice for the beat being accepted.
    always_comb begin
        if (i_in_data.left_diag > r_left_lvl) begin
            n_left_run = (r_left_run < RUN_MAX) ? r_left_run + 1'b1 : r_left_run;
        end else begin
            n_left_run = '0;
        end
        if (i_in_data.right_diag > r_right_lvl) begin
            n_right_run = (r_right_run < RUN_MAX) ? r_right_run + 1'b1 : r_right_run;
        end else begin
            n_right_run = '0;
        end
        if (n_left_run >= RUN_MAX) begin
            n_action = ACT_LEFT;
        end else if (i_in_data.front_distance > r_front_lvl) begin
            n_action = ACT_FWD;
        end else if (n_right_run >= RUN_MAX) begin
            n_action = ACT_RIGHT;
        end else if (i_in_data.front_distance < r_front_lvl) begin
            n_action = ACT_AROUND;
        end else begin
            n_action = ACT_BRAKE;
        end
    end

    assign w_err      = $signed({1'b0, i_in_data.right_side}) -
                        $signed({1'b0, i_in_data.left_side});
    assign w_diff     = {w_err[12], w_err} - {r_prev_error[12], r_prev_error};
    assign w_diff_abs = w_diff[13] ? -w_diff : w_diff;
    // The first PD step uses a fixed interval; a zero interval counts as one.
    assign w_dt = !r_pd_started ? FIRST_DT :
                  (i_in_data.interval_us == '0) ? 20'd1 : i_in_data.interval_us;

    // Restoring division of the scaled error change by the interval.
    assign w_shift = {r_rem, r_quo[QUO_W-1]};
    assign w_trial = w_shift - {1'b0, r_dt};

    assign w_lo_prod = 33'(r_kd) * 33'(r_quo[16:0]);
    assign w_hi_prod = 32'(r_kd) * 32'(r_quo[32:17]);

    assign w_dterm_s = r_diff_neg ? -$signed({3'b000, r_dterm}) : $signed({3'b000, r_dterm});
    assign w_sum     = {{22{r_pterm[29]}}, r_pterm} + w_dterm_s + 52'sd128;

    assign w_corr_x = {{2{r_corr[43]}}, r_corr};
    assign w_base_x = $signed({31'b0, r_base});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp         <= RST_PROP_GAIN;
            r_kd         <= RST_DERIV_GAIN;
            r_left_lvl   <= RST_LEFT_OPEN;
            r_right_lvl  <= RST_RIGHT_OPEN;
            r_front_lvl  <= RST_FRONT_DIST;
            r_ceil       <= RST_DUTY_CEIL;
            r_floor      <= RST_DUTY_FLOOR;
            r_base       <= RST_BASE_DUTY;
            r_prev_error <= '0;
            r_left_run   <= '0;
            r_right_run  <= '0;
            r_pd_started <= 1'b0;
            r_action     <= ACT_BRAKE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PROP_GAIN:  r_kp        <= i_cfg_data;
                    CFG_DERIV_GAIN: r_kd        <= i_cfg_data;
                    CFG_LEFT_OPEN:  r_left_lvl  <= i_cfg_data[11:0];
                    CFG_RIGHT_OPEN: r_right_lvl <= i_cfg_data[11:0];
                    CFG_FRONT_DIST: r_front_lvl <= i_cfg_data;
                    CFG_DUTY_CEIL:  r_ceil      <= i_cfg_data[14:0];
                    CFG_DUTY_FLOOR: r_floor     <= i_cfg_data[14:0];
                    CFG_BASE_DUTY:  r_base      <= i_cfg_data[14:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept) begin
                r_left_run  <= n_left_run;
                r_right_run <= n_right_run;
                r_action    <= n_action;
                if (n_action == ACT_FWD) begin
                    r_prev_error <= w_err;
                    r_pd_started <= 1'b1;
                end else if (n_action != ACT_BRAKE) begin
                    r_prev_error <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_err      <= w_err;
            r_diff_mag <= w_diff_abs[12:0];
            r_diff_neg <= w_diff[13];
            r_dt       <= w_dt;
            r_ldrive   <= '0;
            r_rdrive   <= '0;
        end
        if (i_cmd.prep) begin
            r_quo   <= QUO_W'(r_diff_mag) * QUO_W'(DERIV_SCALE);
            r_rem   <= '0;
            r_pterm <= 30'($signed({1'b0, r_kp})) * 30'(r_err);
        end
        if (i_cmd.div_step) begin
            if (!w_trial[20]) begin
                r_rem <= w_trial[19:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[19:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
        end
        if (i_cmd.mul_lo) begin
            r_dacc <= w_lo_prod;
        end
        if (i_cmd.mul_hi) begin
            r_dterm <= 49'(r_dacc) + {w_hi_prod, 17'b0};
        end
        if (i_cmd.corr) begin
            // Arithmetic shift after adding half an LSB rounds ties upward.
            r_corr <= w_sum[51:8];
        end
        if (i_cmd.drive) begin
            r_lsum <= w_base_x + w_corr_x;
            r_rsum <= w_base_x - w_corr_x;
        end
        if (i_cmd.clamp) begin
            r_ldrive <= clamp_duty(r_lsum, r_ceil, r_floor);
            r_rdrive <= clamp_duty(r_rsum, r_ceil, r_floor);
        end
        if (i_cmd.load_out) begin
            r_out.action      <= r_action;
            r_out.left_drive  <= r_ldrive;
            r_out.right_drive <= r_rdrive;
        end
    end

endmodule

/* verif/tb_wall_follow_pd_junction_steer.sv */
// Self-checking testbench of the wall-following PD steering block with junction detection.
`timescale 1ns / 1ps

module tb_wall_follow_pd_junction_steer;
    import wfs_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_ITEMS = 236;
    localparam int NUM_PHASES  = 8;
    localparam int END_DRAIN   = 60;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [8] = '{
        CFG_PROP_GAIN, CFG_DERIV_GAIN, CFG_LEFT_OPEN, CFG_RIGHT_OPEN,
        CFG_FRONT_DIST, CFG_DUTY_CEIL, CFG_DUTY_FLOOR, CFG_BASE_DUTY
    };

    // Per idle mode: chance in a hundred that the sender idles or the receiver stalls.
    localparam int SEND_IDLE [4] = '{0, 81, 0, 16};
    localparam int RECV_STALL [4] = '{0, 0, 81, 16};

    // Fixed register settings in register order; later phases draw random ones.
    localparam logic [15:0] FIXED_SETS [6][8] = '{
        '{16'd524, 16'd33, 16'd3900, 16'd3900, 16'd100, 16'd25600, 16'd0, 16'd4608},
        '{16'd65535, 16'd65535, 16'd0, 16'd0, 16'd32768, 16'd25600, 16'd0, 16'd12800},
        '{16'd0, 16'd0, 16'd4095, 16'd4095, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd1000, 16'd200, 16'd2000, 16'd2000, 16'd40000, 16'd10000, 16'd20000,
          16'd15000},
        '{16'd65535, 16'd0, 16'd4095, 16'd0, 16'd65535, 16'd25600, 16'd0, 16'd25600},
        '{16'd0, 16'd65535, 16'd100, 16'd3000, 16'd1, 16'd25600, 16'd25600, 16'd0}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  in_data = '0;
    logic      o_out_valid;
    logic      out_ready = 1'b0;
    t_out_item o_out_data;
    logic      cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    wall_follow_pd_junction_steer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Predictor copy of the registers.
    logic [15:0] gain_p      = RST_PROP_GAIN;
    logic [15:0] gain_d      = RST_DERIV_GAIN;
    logic [11:0] left_lvl    = RST_LEFT_OPEN;
    logic [11:0] right_lvl   = RST_RIGHT_OPEN;
    logic [15:0] front_lvl   = RST_FRONT_DIST;
    logic [14:0] duty_hi     = RST_DUTY_CEIL;
    logic [14:0] duty_lo     = RST_DUTY_FLOOR;
    logic [14:0] duty_nom    = RST_BASE_DUTY;

    // Predictor copy of the steering state.
    logic signed [12:0] err_hist   = '0;
    logic [7:0]         left_count = '0;
    logic [7:0]         right_count = '0;
    bit                 pd_armed   = 1'b0;

    t_out_item steer_expect_q [$];
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    typedef struct {
        t_in_item  stim;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    t_dir_row dir_plan [$];

    function automatic longint clamp_drive(input longint v);
        if (v > longint'(duty_hi)) v = longint'(duty_hi);
        if (v < longint'(duty_lo)) v = longint'(duty_lo);
        return v;
    endfunction

    // Advances the state by one tick and returns the steering decision.
    function automatic t_out_item steer_predict(input t_in_item it);
        longint    err;
        longint    dt;
        longint    dv;
        longint    sum;
        longint    corr;
        longint    lv;
        longint    rv;
        t_out_item res;
        res = '0;
        if (it.left_diag > left_lvl) begin
            if (left_count < CONFIRM_TICKS_DEF) left_count++;
        end else begin
            left_count = '0;
        end
        if (it.right_diag > right_lvl) begin
            if (right_count < CONFIRM_TICKS_DEF) right_count++;
        end else begin
            right_count = '0;
        end
        if (left_count >= CONFIRM_TICKS_DEF)
            res.action = ACT_LEFT;
        else if (it.front_distance > front_lvl)
            res.action = ACT_FWD;
        else if (right_count >= CONFIRM_TICKS_DEF)
            res.action = ACT_RIGHT;
        else if (it.front_distance < front_lvl)
            res.action = ACT_AROUND;
        else
            res.action = ACT_BRAKE;

        if (res.action == ACT_FWD) begin
            err = longint'(it.right_side) - longint'(it.left_side);
            dt = pd_armed ? longint'(it.interval_us) : longint'(FIRST_DT);
            if (dt < 1) dt = 1;
            dv = ((err - longint'(err_hist)) * longint'(DERIV_SCALE)) / dt;
            err_hist = err[12:0];
            pd_armed = 1'b1;
            sum = longint'(gain_p) * err + longint'(gain_d) * dv;
            // Arithmetic shift gives the floor, so ties round toward plus infinity.
            corr = (sum + 128) >>> 8;
            lv = clamp_drive(longint'(duty_nom) + corr);
            rv = clamp_drive(longint'(duty_nom) - corr);
            res.left_drive = lv[14:0];
            res.right_drive = rv[14:0];
        end else if (res.action != ACT_BRAKE) begin
            err_hist = '0;
        end
        return res;
    endfunction

    task automatic send_beat(input t_in_item it, input bit typed, input t_out_item want);
        int        gap;
        t_out_item got;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        got = steer_predict(it);
        steer_expect_q.push_back(typed ? want : got);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PROP_GAIN:  gain_p = val;
            CFG_DERIV_GAIN: gain_d = val;
            CFG_LEFT_OPEN:  left_lvl = val[11:0];
            CFG_RIGHT_OPEN: right_lvl = val[11:0];
            CFG_FRONT_DIST: front_lvl = val;
            CFG_DUTY_CEIL:  duty_hi = val[14:0];
            CFG_DUTY_FLOOR: duty_lo = val[14:0];
            CFG_BASE_DUTY:  duty_nom = val[14:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int ph);
        logic [15:0] vals [8];
        if (ph < 6) begin
            for (int j = 0; j < 8; j++) vals[j] = FIXED_SETS[ph][j];
        end else begin
            vals[0] = 16'($urandom_range(65535));
            vals[1] = (ph == 6) ? 16'($urandom_range(2000)) : 16'($urandom_range(65535));
            vals[2] = 16'($urandom_range(4095));
            vals[3] = 16'($urandom_range(4095));
            vals[4] = 16'($urandom_range(65535));
            vals[5] = 16'($urandom_range(25600));
            vals[6] = 16'($urandom_range(vals[5]));
            vals[7] = 16'($urandom_range(25600));
        end
        for (int j = 0; j < 8; j++) write_reg(REG_ORDER[j], vals[j]);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_row(input logic [11:0] rs, input logic [11:0] ls,
                                    input logic [11:0] ld, input logic [11:0] rd,
                                    input logic [15:0] fd, input logic [19:0] iv,
                                    input bit typed, input logic [2:0] act,
                                    input logic [14:0] ldrv, input logic [14:0] rdrv);
        t_dir_row row;
        row.stim = '{right_side: rs, left_side: ls, left_diag: ld, right_diag: rd,
                     front_distance: fd, interval_us: iv};
        row.typed = typed;
        row.want = '{action: act, left_drive: ldrv, right_drive: rdrv};
        dir_plan.push_back(row);
    endfunction

    function automatic logic [11:0] diag_sample(input logic [11:0] lvl, input bit open);
        if (open)
            return (lvl == 12'd4095) ? 12'd4095 : 12'($urandom_range(4095, lvl + 1));
        return 12'($urandom_range(lvl, 0));
    endfunction

    // Well-formed tick: diagonals held open or closed for a run, front near its threshold.
    function automatic t_in_item sequence_item(input bit want_l, input bit want_r);
        t_in_item    it;
        int          b;
        int          d;
        logic [15:0] f;
        it = '0;
        it.left_diag = diag_sample(left_lvl, want_l ^ ($urandom_range(99) < 8));
        it.right_diag = diag_sample(right_lvl, want_r ^ ($urandom_range(99) < 8));
        f = front_lvl;
        case ($urandom_range(5))
            0: it.front_distance = (f == 16'd0) ? f : f - 16'd1;
            1: it.front_distance = f;
            2: it.front_distance = (f == 16'hFFFF) ? f : f + 16'd1;
            3: it.front_distance = (f == 16'hFFFF) ? f : 16'($urandom_range(65535, f + 1));
            4: it.front_distance = 16'($urandom_range(f, 0));
            default: it.front_distance = 16'($urandom_range(65535));
        endcase
        if ($urandom_range(99) < 60) begin
            b = $urandom_range(4095);
            d = $urandom_range(400) - 200;
            d = b + d;
            if (d < 0) d = 0;
            if (d > 4095) d = 4095;
            it.right_side = 12'(b);
            it.left_side = 12'(d);
        end else begin
            it.right_side = 12'($urandom_range(4095));
            it.left_side = 12'($urandom_range(4095));
        end
        case ($urandom_range(9))
            0: it.interval_us = 20'($urandom_range(1));
            1: it.interval_us = 20'd1000000;
            2, 3: it.interval_us = 20'($urandom_range(1000000));
            default: it.interval_us = 20'($urandom_range(15000, 5000));
        endcase
        return it;
    endfunction

    function automatic t_in_item noise_item();
        t_in_item it;
        it.right_side = 12'($urandom_range(4095));
        it.left_side = 12'($urandom_range(4095));
        it.left_diag = 12'($urandom_range(4095));
        it.right_diag = 12'($urandom_range(4095));
        it.front_distance = 16'($urandom_range(65535));
        it.interval_us = 20'($urandom_range(1000000));
        return it;
    endfunction

    // Receiver side: result checks, random back-pressure and the idle counter.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (steer_expect_q.size() == 0) begin
                $display("%0t unexpected result beat: action %0d left %0d right %0d",
                         $time, o_out_data.action, o_out_data.left_drive,
                         o_out_data.right_drive);
                mismatches++;
            end else begin
                want = steer_expect_q.pop_front();
                if (o_out_data.action !== want.action) begin
                    $display("%0t action: expected %0d, got %0d",
                             $time, want.action, o_out_data.action);
                    mismatches++;
                end
                if (o_out_data.left_drive !== want.left_drive) begin
                    $display("%0t left_drive: expected %0d, got %0d",
                             $time, want.left_drive, o_out_data.left_drive);
                    mismatches++;
                end
                if (o_out_data.right_drive !== want.right_drive) begin
                    $display("%0t right_drive: expected %0d, got %0d",
                             $time, want.right_drive, o_out_data.right_drive);
                    mismatches++;
                end
            end
        end
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        out_ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_wall_follow_pd_junction_steer: errors");
        $finish;
    end

    initial begin
        int       sent;
        int       seg_len;
        bit       noisy;
        bit       want_l;
        bit       want_r;
        t_in_item it;

        // Reset values, the front threshold itself, zero interval and the
        // confirm runs of both diagonals.
        add_row(0, 0, 0, 0, 0, 0, 1, ACT_AROUND, 0, 0);
        add_row(4095, 4095, 0, 0, 100, 1, 1, ACT_BRAKE, 0, 0);
        add_row(2048, 2048, 0, 0, 101, 500, 1, ACT_FWD, 4608, 4608);
        add_row(4095, 0, 0, 0, 65535, 1000000, 0, ACT_FWD, 0, 0);
        add_row(0, 4095, 0, 0, 65535, 0, 0, ACT_FWD, 0, 0);
        add_row(1000, 1000, 0, 0, 0, 0, 1, ACT_AROUND, 0, 0);
        add_row(1000, 1000, 0, 0, 200, 10000, 1, ACT_FWD, 4608, 4608);
        add_row(3000, 1000, 0, 0, 200, 10000, 0, ACT_FWD, 0, 0);
        add_row(0, 0, 0, 0, 100, 1, 1, ACT_BRAKE, 0, 0);
        add_row(3000, 1000, 0, 0, 200, 10000, 0, ACT_FWD, 0, 0);
        repeat (4) add_row(0, 0, 4095, 0, 0, 1, 1, ACT_AROUND, 0, 0);
        add_row(0, 0, 4095, 0, 0, 1, 1, ACT_LEFT, 0, 0);
        add_row(0, 0, 4095, 4095, 65535, 1, 1, ACT_LEFT, 0, 0);
        add_row(0, 0, 3900, 4095, 65535, 1, 0, ACT_FWD, 0, 0);
        repeat (3) add_row(0, 0, 0, 4095, 65535, 1, 0, ACT_FWD, 0, 0);
        add_row(0, 0, 0, 3901, 100, 1, 1, ACT_RIGHT, 0, 0);
        add_row(0, 0, 0, 3901, 0, 1, 1, ACT_RIGHT, 0, 0);
        add_row(0, 0, 0, 3900, 0, 1, 1, ACT_AROUND, 0, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_plan[n]) send_beat(dir_plan[n].stim, dir_plan[n].typed, dir_plan[n].want);
        in_valid <= 1'b0;
        while (steer_expect_q.size() != 0) @(posedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            apply_setting(ph);
            send_idle_pct = SEND_IDLE[ph % 4];
            recv_stall_pct = RECV_STALL[ph % 4];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                seg_len = $urandom_range(12, 1);
                noisy = ($urandom_range(99) < 15);
                want_l = ($urandom_range(99) < 45);
                want_r = ($urandom_range(99) < 45);
                for (int k = 0; k < seg_len && sent < PHASE_ITEMS; k++) begin
                    it = noisy ? noise_item() : sequence_item(want_l, want_r);
                    send_beat(it, 1'b0, '0);
                    sent++;
                end
            end
            in_valid <= 1'b0;
            while (steer_expect_q.size() != 0) @(posedge i_clk);
        end

        repeat (END_DRAIN) @(posedge i_clk);
        if (mismatches == 0 && steer_expect_q.size() == 0)
            $display("tb_wall_follow_pd_junction_steer: clean");
        else
            $display("tb_wall_follow_pd_junction_steer: errors");
        $finish;
    end

endmodule
